// ===== hw/rtl/llm_pkg.sv =====
// Shared types and constants for the Louvain local-moving engine.
// No dependencies; imported by llm_mul and louvain_local_move.
`default_nettype none
package llm_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int CNT_W     = NODE_W + 1;

  localparam int WT_W   = 24;   // Q8.16 weight
  localparam int SUM_W  = 40;   // link sums and strengths, wrap mod 2^40
  localparam int GAIN_W = 48;   // Q32.16 gain
  localparam int CFG_W  = 32;

  // multiplier operand and product widths
  localparam int MUL_A_W = 72;
  localparam int MUL_B_W = 42;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_MOVE  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SCALE      = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

  localparam logic [6:0] NODE_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] SCALE_RST = 32'd65536;

  typedef struct packed {
    logic [1:0]        action;
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic [WT_W-1:0]   weight;
  } in_beat_t;

  typedef struct packed {
    logic                     moved;
    logic [NODE_W-1:0]        community;
    logic signed [GAIN_W-1:0] gain;
    logic                     status;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/llm_mul.sv =====
// Multi-cycle unsigned multiplier, 72 x 42 bits, one 24 x 21 partial product per cycle.
// Depends on llm_pkg.
`default_nettype none
module llm_mul
  import llm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      p
);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic               busy;
  logic [1:0]         ia;
  logic               ib;
  logic [44:0]        pp;
  logic [6:0]         pp_sh;
  logic               pp_v;
  logic               pp_last;
  logic [MUL_P_W-1:0] acc;

  logic [23:0] a_ch;
  logic [20:0] b_ch;
  logic [6:0]  a_off;
  logic        last;

  always_comb begin
    case (ia)
      2'd0: begin
        a_ch  = a_r[23:0];
        a_off = 7'd0;
      end
      2'd1: begin
        a_ch  = a_r[47:24];
        a_off = 7'd24;
      end
      default: begin
        a_ch  = a_r[71:48];
        a_off = 7'd48;
      end
    endcase
    b_ch = ib ? b_r[41:21] : b_r[20:0];
    last = (ia == 2'd2) && ib;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pp_v    <= 1'b0;
      pp_last <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= pp_v && pp_last;
      if (pp_v) begin
        acc <= acc + (MUL_P_W'(pp) << pp_sh);
      end
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        ia   <= 2'd0;
        ib   <= 1'b0;
        busy <= 1'b1;
        acc  <= '0;
        pp_v <= 1'b0;
      end else if (busy) begin
        pp      <= 45'(a_ch) * 45'(b_ch);
        pp_sh   <= a_off + (ib ? 7'd21 : 7'd0);
        pp_v    <= 1'b1;
        pp_last <= last;
        if (ia == 2'd2) begin
          ia <= 2'd0;
          ib <= 1'b1;
        end else begin
          ia <= ia + 2'd1;
        end
        if (last) busy <= 1'b0;
      end else begin
        pp_v <= 1'b0;
      end
    end
  end

  assign p = acc;

endmodule
`default_nettype wire

// ===== hw/rtl/louvain_local_move.sv =====
// Louvain local-moving engine: top level with state memories and sequencer.
// Depends on llm_pkg and llm_mul.
//
// One input beat gives one output beat. Each candidate community other than
// the node's own costs a memory read (S_SC_RD), a setup state (S_SC_CALC), a
// wait on the shared partial-product multiplier for k*x*s (S_SC_MUL), and a
// compare (S_SC_CMP); the own community skips the multiplier wait, and the k*s
// setup at the start of a move waits on the same multiplier. The move itself
// then sweeps two link-sum columns row by row through S_UP0, S_UP1 and S_UP2
// over the link-sum RAM (one read and one write port). Weights and link sums
// sit in 4096-entry RAMs with no reset; node strength, community strength and
// community membership sit in 64-entry RAMs backed by per-entry valid bits,
// so a start beat clears them at once.
// A new beat is taken whenever the sequencer is idle, even while the last
// result still waits in the output register. Config writes land immediately.
`default_nettype none
module louvain_local_move
  import llm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_beat_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_beat_t             out_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_LD_WB, S_RD_WAIT, S_MV_A, S_MV_B, S_SC_RD, S_SC_CALC, S_SC_MUL,
    S_SC_CMP, S_MV_DEC, S_UP0, S_UP1, S_UP2, S_CS0, S_CS1, S_CS2, S_OUT
  } state_t;

  state_t state;

  // config registers
  logic [6:0]       node_count;
  logic [CFG_W-1:0] strength_scale;
  logic [15:0]      gain_threshold;
  logic [CNT_W-1:0] n_eff;

  // latched beat
  logic [NODE_W-1:0] row;
  logic [NODE_W-1:0] col;
  logic [WT_W-1:0]   wt;

  // move working set
  logic [NODE_W-1:0]        m;
  logic [SUM_W-1:0]         k;
  logic [WT_W-1:0]          wii;
  logic [SUM_W-1:0]         lm;
  logic [SUM_W-1:0]         cm;
  logic [MUL_A_W-1:0]       ks;
  logic                     neg;
  logic signed [41:0]       a_r;
  logic signed [GAIN_W-1:0] g;
  logic signed [GAIN_W-1:0] best;
  logic [NODE_W-1:0]        pick;
  logic [CNT_W-1:0]         j;
  logic [CNT_W-1:0]         z;
  logic [WT_W-1:0]          w_hold;
  out_beat_t                res;

  // memories
  logic [WT_W-1:0]   wmem  [0:MAX_NODES*MAX_NODES-1];
  logic [SUM_W-1:0]  lmem  [0:MAX_NODES*MAX_NODES-1];
  logic [SUM_W-1:0]  nsmem [0:MAX_NODES-1];
  logic [SUM_W-1:0]  csmem [0:MAX_NODES-1];
  logic [NODE_W-1:0] cnmem [0:MAX_NODES-1];
  logic [MAX_NODES-1:0] ns_vld, cs_vld, cn_vld;

  logic [ADDR_W-1:0] w_raddr, l_raddr, l_waddr;
  logic              w_we, l_we;
  logic [SUM_W-1:0]  l_wdata;
  logic [WT_W-1:0]   w_rd;
  logic [SUM_W-1:0]  l_rd;
  logic [NODE_W-1:0] ns_raddr, cs_raddr, cs_waddr, cn_raddr;
  logic              ns_we, cs_we, cn_we;
  logic [SUM_W-1:0]  ns_wdata, cs_wdata;
  logic [SUM_W-1:0]  ns_rd, cs_rd;
  logic [NODE_W-1:0] cn_rd, cn_aq;
  logic              ns_vq, cs_vq, cn_vq;
  logic [SUM_W-1:0]  ns_q, cs_q;
  logic [NODE_W-1:0] cn_q;
  logic              clear_all;

  // multiplier
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // datapath temporaries
  logic signed [41:0]       a_v, x_v;
  logic [MUL_B_W-1:0]       x_mag;
  logic [SUM_W-1:0]         k_mag;
  logic [49:0]              p_mag;
  logic signed [51:0]       diff;
  logic signed [GAIN_W-1:0] g_sat;
  logic                     bad;
  logic                     accept;

  llm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign n_eff    = (node_count > 7'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign bad      = (CNT_W'(in_data.row) >= n_eff)
                 || ((in_data.action == ACT_LOAD) && (CNT_W'(in_data.col) >= n_eff));

  // invalid entries read as their reset value
  assign ns_q = ns_vq ? ns_rd : '0;
  assign cs_q = cs_vq ? cs_rd : '0;
  assign cn_q = cn_vq ? cn_rd : cn_aq;

  // gain datapath
  always_comb begin
    a_v   = $signed({{2{l_rd[SUM_W-1]}}, l_rd}) + $signed({18'd0, wii})
          - $signed({{2{lm[SUM_W-1]}}, lm});
    x_v   = $signed({{2{cs_q[SUM_W-1]}}, cs_q}) + $signed({{2{k[SUM_W-1]}}, k})
          - $signed({{2{cm[SUM_W-1]}}, cm});
    x_mag = x_v[41] ? MUL_B_W'(-x_v) : MUL_B_W'(x_v);
    k_mag = ns_q[SUM_W-1] ? (~ns_q + 1'b1) : ns_q;
    // k*x*s >> 48, capped at 2^49 once the product reaches 2^96
    p_mag = (mul_p[MUL_P_W-1:96] != '0) ? (50'd1 << 49) : {2'd0, mul_p[95:48]};
    diff  = neg ? ({{10{a_r[41]}}, a_r} + $signed({2'd0, p_mag}))
                : ({{10{a_r[41]}}, a_r} - $signed({2'd0, p_mag}));
    if (diff[51:47] == 5'b00000 || diff[51:47] == 5'b11111) begin
      g_sat = diff[GAIN_W-1:0];
    end else if (diff[51]) begin
      g_sat = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      g_sat = {1'b0, {(GAIN_W-1){1'b1}}};
    end
  end

  // memory addressing per state
  always_comb begin
    w_raddr   = {in_data.row, in_data.row};
    l_raddr   = {row, m};
    l_waddr   = {row, col};
    l_we      = 1'b0;
    l_wdata   = SUM_W'(wt);
    w_we      = 1'b0;
    ns_raddr  = in_data.row;
    ns_we     = 1'b0;
    ns_wdata  = ns_q + SUM_W'(wt);
    cs_raddr  = in_data.row;
    cs_waddr  = row;
    cs_we     = 1'b0;
    cs_wdata  = cs_q + SUM_W'(wt);
    cn_raddr  = in_data.row;
    cn_we     = 1'b0;
    mul_start = 1'b0;
    mul_a     = ks;
    mul_b     = x_mag;
    clear_all = 1'b0;
    case (state)
      S_IDLE: begin
        clear_all = accept && (in_data.action == ACT_START);
      end
      S_LD_WB: begin
        w_we  = 1'b1;
        l_we  = 1'b1;
        ns_we = 1'b1;
        cs_we = 1'b1;
      end
      S_MV_A: begin
        l_raddr   = {row, cn_q};
        cs_raddr  = cn_q;
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(k_mag);
        mul_b     = MUL_B_W'(strength_scale);
      end
      S_MV_B: begin
        // keep the own-community strength on the read port while k*s runs
        cs_raddr = m;
      end
      S_SC_RD: begin
        l_raddr  = {row, j[NODE_W-1:0]};
        cs_raddr = j[NODE_W-1:0];
      end
      S_SC_CALC: begin
        mul_start = (j[NODE_W-1:0] != m);
      end
      S_UP0: begin
        w_raddr = {z[NODE_W-1:0], row};
        l_raddr = {z[NODE_W-1:0], pick};
      end
      S_UP1: begin
        l_we    = 1'b1;
        l_waddr = {z[NODE_W-1:0], pick};
        l_wdata = l_rd + SUM_W'(w_rd);
        l_raddr = {z[NODE_W-1:0], m};
      end
      S_UP2: begin
        l_we    = 1'b1;
        l_waddr = {z[NODE_W-1:0], m};
        l_wdata = l_rd - SUM_W'(w_hold);
      end
      S_CS0: begin
        cs_raddr = pick;
      end
      S_CS1: begin
        cs_we    = 1'b1;
        cs_waddr = pick;
        cs_wdata = cs_q + k;
        cs_raddr = m;
      end
      S_CS2: begin
        cs_we    = 1'b1;
        cs_waddr = m;
        cs_wdata = cs_q - k;
        cn_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // RAMs, registered reads
  always_ff @(posedge clk) begin
    if (w_we) wmem[{row, col}] <= wt;
    w_rd <= wmem[w_raddr];
    if (l_we) lmem[l_waddr] <= l_wdata;
    l_rd <= lmem[l_raddr];
    if (ns_we) nsmem[row] <= ns_wdata;
    ns_rd <= nsmem[ns_raddr];
    if (cs_we) csmem[cs_waddr] <= cs_wdata;
    cs_rd <= csmem[cs_raddr];
    if (cn_we) cnmem[row] <= pick;
    cn_rd <= cnmem[cn_raddr];
    cn_aq <= cn_raddr;
  end

  // valid bits stand in for the reset/start clear of the small stores
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      ns_vld <= '0;
      cs_vld <= '0;
      cn_vld <= '0;
      ns_vq  <= 1'b0;
      cs_vq  <= 1'b0;
      cn_vq  <= 1'b0;
    end else begin
      if (ns_we) ns_vld[row] <= 1'b1;
      if (cs_we) cs_vld[cs_waddr] <= 1'b1;
      if (cn_we) cn_vld[row] <= 1'b1;
      ns_vq <= ns_vld[ns_raddr];
      cs_vq <= cs_vld[cs_raddr];
      cn_vq <= cn_vld[cn_raddr];
    end
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= NODE_COUNT_RST;
      strength_scale <= SCALE_RST;
      gain_threshold <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count     <= cfg_data[6:0];
        CFG_SCALE:      strength_scale <= cfg_data;
        CFG_THRESHOLD:  gain_threshold <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_OUT sets out_valid itself whenever the output register frees up
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            row <= in_data.row;
            col <= in_data.col;
            wt  <= in_data.weight;
            res <= '{moved: 1'b0, community: '0, gain: '0,
                     status: (in_data.action != ACT_START) && bad};
            if (in_data.action == ACT_START) begin
              state <= S_OUT;
            end else if (bad) begin
              state <= S_OUT;
            end else if (in_data.action == ACT_LOAD) begin
              state <= S_LD_WB;
            end else if (in_data.action == ACT_MOVE) begin
              state <= S_MV_A;
            end else begin
              state <= S_RD_WAIT;
            end
          end
        end
        S_LD_WB, S_RD_WAIT: begin
          res.community <= cn_q;
          state         <= S_OUT;
        end
        S_MV_A: begin
          m     <= cn_q;
          k     <= ns_q;
          wii   <= w_rd;
          state <= S_MV_B;
        end
        S_MV_B: begin
          lm <= l_rd;
          cm <= cs_q;
          if (mul_done) begin
            ks    <= mul_p[MUL_A_W-1:0];
            j     <= '0;
            state <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          state <= S_SC_CALC;
        end
        S_SC_CALC: begin
          a_r <= a_v;
          neg <= k[SUM_W-1] != x_v[41];
          if (j[NODE_W-1:0] == m) begin
            g     <= '0;
            state <= S_SC_CMP;
          end else begin
            state <= S_SC_MUL;
          end
        end
        S_SC_MUL: begin
          if (mul_done) begin
            g     <= g_sat;
            state <= S_SC_CMP;
          end
        end
        S_SC_CMP: begin
          // first maximum wins
          if (j == '0 || g > best) begin
            best <= g;
            pick <= j[NODE_W-1:0];
          end
          if (j + 1'b1 == n_eff) begin
            state <= S_MV_DEC;
          end else begin
            j     <= j + 1'b1;
            state <= S_SC_RD;
          end
        end
        S_MV_DEC: begin
          res.gain <= best;
          if (best > $signed({{(GAIN_W-16){1'b0}}, gain_threshold})) begin
            z     <= '0;
            state <= S_UP0;
          end else begin
            res.community <= m;
            state         <= S_OUT;
          end
        end
        S_UP0: begin
          state <= S_UP1;
        end
        S_UP1: begin
          w_hold <= w_rd;
          state  <= S_UP2;
        end
        S_UP2: begin
          if (z + 1'b1 == n_eff) begin
            state <= S_CS0;
          end else begin
            z     <= z + 1'b1;
            state <= S_UP0;
          end
        end
        S_CS0: begin
          state <= S_CS1;
        end
        S_CS1: begin
          state <= S_CS2;
        end
        S_CS2: begin
          res.moved     <= 1'b1;
          res.community <= pick;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
